>>> rtl/prr_pkg.sv
package prr_pkg;

  localparam int unsigned DEF_WINDOW = 32;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned HND_W  = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ENTRY_W = LEN_W + HND_W;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_ACK = 2'd2;

  // "eeee"
  localparam logic [SEQ_W-1:0] END_ACK_SEQ = 32'h6565_6565;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_RD,
    S_DLV,
    S_END
  } state_e;

endpackage

>>> rtl/prr_if.sv
interface prr_pkt_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [prr_pkg::SEQ_W-1:0]  seq;
  logic [prr_pkg::LEN_W-1:0]  length;
  logic [prr_pkg::HND_W-1:0]  handle;

  modport source (output valid, func, seq, length, handle, input ready);
  modport sink   (input valid, func, seq, length, handle, output ready);
endinterface

interface prr_res_if;
  logic                        valid;
  logic                        ready;
  logic [prr_pkg::KIND_W-1:0]  kind;
  logic [prr_pkg::SEQ_W-1:0]   out_seq;
  logic [prr_pkg::LEN_W-1:0]   out_length;
  logic [prr_pkg::HND_W-1:0]   out_handle;
  logic                        last;

  modport source (output valid, kind, out_seq, out_length, out_handle, last, input ready);
  modport sink   (input valid, kind, out_seq, out_length, out_handle, last, output ready);
endinterface

>>> rtl/prr_slot_ram.sv
module prr_slot_ram #(
  parameter int unsigned DEPTH = prr_pkg::DEF_WINDOW,
  parameter int unsigned WIDTH = prr_pkg::ENTRY_W,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/packet_reorder_receiver.sv
// Selective-repeat receive reorder buffer. A data word whose seq lies in
// [expected, expected + WINDOW) modulo 2^32 is parked in a slot RAM unless
// its slot is already full; anything else is dropped. The block then emits
// every in-order stored packet (kind deliver) and closes with a cumulative
// ack (kind ack, last set) carrying the next expected seq. An end word gives
// a single end ack and empties the buffer. Payload bytes stay outside; only
// length and buffer handle are kept. One packet is handled at a time: a data
// word is stored (or dropped) after acceptance, then each delivery is a read
// of the slot RAM followed by the output load, and the ack enters the output
// register last. An end word loads its end ack directly. Output backpressure
// stalls each output load. No clearing pass is needed after reset; slot valid
// bits live in flops.
module packet_reorder_receiver #(
  parameter int unsigned WINDOW = prr_pkg::DEF_WINDOW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  prr_pkt_if.sink         pkt_i,
  prr_res_if.source       res_o
);

  localparam int unsigned IdxW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  prr_pkg::state_e state_q, state_d;

  logic [prr_pkg::SEQ_W-1:0] expected_q;
  logic [IdxW-1:0]           head_q;
  logic [WINDOW-1:0]         slot_valid_q;

  logic [prr_pkg::SEQ_W-1:0] seq_q;
  logic [prr_pkg::LEN_W-1:0] len_q;
  logic [prr_pkg::HND_W-1:0] hnd_q;

  logic                       out_valid_q;
  logic [prr_pkg::KIND_W-1:0] out_kind_q, out_kind_d;
  logic [prr_pkg::SEQ_W-1:0]  out_seq_q, out_seq_d;
  logic [prr_pkg::LEN_W-1:0]  out_len_q, out_len_d;
  logic [prr_pkg::HND_W-1:0]  out_hnd_q, out_hnd_d;
  logic                       out_last_q, out_last_d;

  logic [prr_pkg::SEQ_W-1:0]   off;
  logic                        in_win;
  logic [IdxW:0]               idx_sum;
  logic [IdxW-1:0]             store_idx;
  logic [IdxW-1:0]             head_nxt;
  logic [prr_pkg::ENTRY_W-1:0] rdata;

  logic in_ready, accept, out_free, out_load;
  logic ram_we, ram_re, dlv_step, clr;

  // window position
  assign off     = seq_q - expected_q;
  assign in_win  = off < prr_pkg::SEQ_W'(WINDOW);
  assign idx_sum = {1'b0, head_q} + {1'b0, off[IdxW-1:0]};
  assign store_idx = (idx_sum >= (IdxW+1)'(WINDOW)) ?
                     IdxW'(idx_sum - (IdxW+1)'(WINDOW)) : idx_sum[IdxW-1:0];
  assign head_nxt = (head_q == IdxW'(WINDOW - 1)) ? '0 : head_q + 1'b1;

  assign accept   = pkt_i.valid && in_ready;
  assign out_free = !out_valid_q || res_o.ready;

  prr_slot_ram #(
    .DEPTH (WINDOW),
    .WIDTH (prr_pkg::ENTRY_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (store_idx),
    .wdata_i ({len_q, hnd_q}),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d    = state_q;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    out_load   = 1'b0;
    dlv_step   = 1'b0;
    clr        = 1'b0;
    out_kind_d = prr_pkg::KIND_ACK;
    out_seq_d  = expected_q;
    out_len_d  = '0;
    out_hnd_d  = '0;
    out_last_d = 1'b1;
    case (state_q)
      prr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (pkt_i.valid) begin
          state_d = (pkt_i.func == prr_pkg::FUNC_END) ? prr_pkg::S_END : prr_pkg::S_STORE;
        end
      end
      prr_pkg::S_STORE: begin
        ram_we  = in_win && !slot_valid_q[store_idx];
        state_d = prr_pkg::S_RD;
      end
      prr_pkg::S_RD: begin
        if (slot_valid_q[head_q]) begin
          ram_re  = 1'b1;
          state_d = prr_pkg::S_DLV;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = prr_pkg::S_IDLE;
        end
      end
      prr_pkg::S_DLV: begin
        out_kind_d = prr_pkg::KIND_DELIVER;
        out_len_d  = rdata[prr_pkg::ENTRY_W-1:prr_pkg::HND_W];
        out_hnd_d  = rdata[prr_pkg::HND_W-1:0];
        out_last_d = 1'b0;
        if (out_free) begin
          out_load = 1'b1;
          dlv_step = 1'b1;
          state_d  = prr_pkg::S_RD;
        end
      end
      prr_pkg::S_END: begin
        out_kind_d = prr_pkg::KIND_END_ACK;
        out_seq_d  = prr_pkg::END_ACK_SEQ;
        if (out_free) begin
          out_load = 1'b1;
          clr      = 1'b1;
          state_d  = prr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = prr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q   <= '0;
      head_q       <= '0;
      slot_valid_q <= '0;
    end else if (clr) begin
      expected_q   <= '0;
      head_q       <= '0;
      slot_valid_q <= '0;
    end else begin
      if (ram_we) begin
        slot_valid_q[store_idx] <= 1'b1;
      end
      if (dlv_step) begin
        slot_valid_q[head_q] <= 1'b0;
        expected_q           <= expected_q + 1'b1;
        head_q               <= head_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q <= pkt_i.seq;
      len_q <= pkt_i.length;
      hnd_q <= pkt_i.handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_seq_q  <= out_seq_d;
      out_len_q  <= out_len_d;
      out_hnd_q  <= out_hnd_d;
      out_last_q <= out_last_d;
    end
  end

  assign pkt_i.ready      = in_ready;
  assign res_o.valid      = out_valid_q;
  assign res_o.kind       = out_kind_q;
  assign res_o.out_seq    = out_seq_q;
  assign res_o.out_length = out_len_q;
  assign res_o.out_handle = out_hnd_q;
  assign res_o.last       = out_last_q;

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= IdxW'(WINDOW - 1))
    else $error("head pointer out of range");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == prr_pkg::S_IDLE |-> !slot_valid_q[head_q])
    else $error("idle with an in-order slot still pending");

  a_dlv_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == prr_pkg::S_DLV |-> slot_valid_q[head_q])
    else $error("delivering from an empty slot");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (slot_valid_q == '0 && expected_q == '0 && head_q == '0))
    else $error("end of transfer did not clear the buffer");

  a_last_is_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_kind_q != prr_pkg::KIND_DELIVER)))
    else $error("last flag does not match word kind");

endmodule
